FILE: rtl/bsev_pkg.sv
// ----------------------------------------------------------------------------
// bsev_pkg
// Shared types, codes and constants of the Bezier surface evaluator.
// ----------------------------------------------------------------------------
package bsev_pkg;

  localparam int MAX_GRID_DIM = 8;
  localparam int COORD_WIDTH  = 32;
  localparam int DIM_IW       = $clog2(MAX_GRID_DIM);
  localparam int STORE_DEPTH  = MAX_GRID_DIM * MAX_GRID_DIM;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int NUM_W        = 28;
  localparam int DIV_STEPS    = NUM_W;
  localparam int BIN_W        = 6;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_MOVE  = 2'd1;
  localparam logic [1:0] OP_EVAL  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_FEW_PTS   = 2'd2;

  localparam logic [1:0] CFG_PPR = 2'd0;
  localparam logic [1:0] CFG_ROP = 2'd1;
  localparam logic [1:0] CFG_SU  = 2'd2;
  localparam logic [1:0] CFG_SV  = 2'd3;

  localparam logic [1:0] RES_ZERO  = 2'd0;
  localparam logic [1:0] RES_POINT = 2'd1;
  localparam logic [1:0] RES_EVAL  = 2'd2;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef struct packed {
    logic        [1:0]  operation;
    logic        [5:0]  point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic        [11:0] sample_u_index;
    logic        [11:0] sample_v_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [16:0] param_u;
    logic        [16:0] param_v;
    logic        [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  ppr;
    logic [3:0]  rop;
    logic [12:0] su;
    logic [12:0] sv;
  } cfg_t;

  typedef struct packed {
    logic              load_item;
    logic              div_step;
    logic              bern_step;
    logic [DIM_IW-1:0] bern_idx;
    logic              bern_cap;
    logic              acc_issue;
    logic [ADDR_W-1:0] acc_addr;
    logic [DIM_IW-1:0] acc_k;
    logic [DIM_IW-1:0] acc_l;
    logic              pt_read;
    logic              pt_write;
    logic              pt_move;
    logic              res_load;
    logic [1:0]        res_sel;
    logic [1:0]        res_status;
  } cmd_t;

  typedef logic [MAX_GRID_DIM-1:0][MAX_GRID_DIM-1:0][BIN_W-1:0] binom_tab_t;

  function automatic binom_tab_t make_binom();
    binom_tab_t t;
    t = '0;
    t[0][0] = BIN_W'(1);
    for (int n = 1; n < MAX_GRID_DIM; n++) begin
      t[n][0] = BIN_W'(1);
      for (int k = 1; k <= n; k++) begin
        t[n][k] = t[n-1][k-1] + ((k < n) ? t[n-1][k] : BIN_W'(0));
      end
    end
    return t;
  endfunction

  localparam binom_tab_t BINOM_TAB = make_binom();

endpackage

FILE: rtl/bsev_ram.sv
// ----------------------------------------------------------------------------
// bsev_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bsev_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bsev_dp.sv
// ----------------------------------------------------------------------------
// bsev_dp
// Datapath: parameter dividers, Bernstein lanes, point store and accumulator.
// ----------------------------------------------------------------------------
module bsev_dp #(
  parameter int CoordW = bsev_pkg::COORD_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bsev_pkg::cfg_t      cfg_i,
  input  bsev_pkg::cmd_t      cmd_i,
  input  bsev_pkg::in_item_t  item_i,
  output bsev_pkg::out_item_t result_o
);
  import bsev_pkg::*;

  localparam int ExtW  = ((CoordW > 32) ? CoordW : 32) + 1;
  localparam int AccW  = CoordW + 8;
  localparam int XW    = (AccW > ExtW) ? AccW : ExtW;
  localparam int ProdW = CoordW + 18;
  localparam int MD    = MAX_GRID_DIM;

  localparam logic signed [XW-1:0] CwMax = {{(XW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}};
  localparam logic signed [XW-1:0] CwMin = ~CwMax;
  localparam logic signed [XW-1:0] O32Max = {{(XW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [XW-1:0] O32Min = ~O32Max;

  function automatic logic signed [CoordW-1:0] sat_cw(input logic signed [XW-1:0] x);
    if (x > CwMax) return CwMax[CoordW-1:0];
    if (x < CwMin) return CwMin[CoordW-1:0];
    return x[CoordW-1:0];
  endfunction

  function automatic logic signed [31:0] sat_32(input logic signed [XW-1:0] x);
    if (x > O32Max) return O32Max[31:0];
    if (x < O32Min) return O32Min[31:0];
    return x[31:0];
  endfunction

  in_item_t item_q;

  // parameter dividers, one lane per axis
  logic [11:0]      den     [2];
  logic [3:0]       dim     [2];
  logic [11:0]      sidx    [2];
  logic [NUM_W-1:0] quo_q   [2];
  logic [NUM_W-1:0] quo_d   [2];
  logic [11:0]      rem_q   [2];
  logic [11:0]      rem_d   [2];
  logic [12:0]      rsh     [2];
  logic             ge      [2];
  logic [16:0]      par     [2];
  logic [DIM_IW-1:0] nm1    [2];

  // bernstein lanes
  logic [16:0] p_q   [2][MD];
  logic [16:0] p_d   [2][MD];
  logic [16:0] w_q   [2][MD];
  logic [16:0] w_d   [2][MD];
  logic [16:0] fac   [2][MD];
  logic [33:0] mul   [2][MD];
  logic [22:0] capm  [2][MD];
  logic        act   [2];

  // accumulation
  logic [33:0]              wprod;
  logic [16:0]              wt_q;
  logic                     iss_q;
  logic                     mul_q;
  logic [3*CoordW-1:0]      rdata;
  logic                     rd_vld_q;
  logic [STORE_DEPTH-1:0]   valid_q;
  logic signed [CoordW-1:0] cur    [3];
  logic signed [31:0]       dcoord [3];
  logic signed [ProdW-1:0]  prod_q [3];
  logic signed [ProdW-1:0]  rsum   [3];
  logic signed [AccW-1:0]   acc_q  [3];
  logic signed [CoordW-1:0] new_pt [3];
  logic signed [CoordW-1:0] pt_q   [3];
  logic signed [31:0]       pos    [3];

  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;

  out_item_t res_q;
  out_item_t res_d;

  assign den[0]  = 12'(cfg_i.su - 13'd1);
  assign den[1]  = 12'(cfg_i.sv - 13'd1);
  assign dim[0]  = cfg_i.ppr;
  assign dim[1]  = cfg_i.rop;
  assign sidx[0] = item_i.sample_u_index;
  assign sidx[1] = item_i.sample_v_index;

  assign dcoord[0] = item_q.coord_x;
  assign dcoord[1] = item_q.coord_y;
  assign dcoord[2] = item_q.coord_z;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      rsh[a]   = {rem_q[a], quo_q[a][NUM_W-1]};
      ge[a]    = rsh[a] >= {1'b0, den[a]};
      rem_d[a] = ge[a] ? 12'(rsh[a] - {1'b0, den[a]}) : rsh[a][11:0];
      quo_d[a] = {quo_q[a][NUM_W-2:0], ge[a]};
      par[a]   = quo_q[a][16:0];
      nm1[a]   = DIM_IW'(dim[a] - 4'd1);
      act[a]   = (4'({1'b0, cmd_i.bern_idx}) + 4'd1) < dim[a];
      for (int i = 0; i < MD; i++) begin
        fac[a][i]  = (cmd_i.bern_idx < DIM_IW'(i)) ? par[a] : 17'(ONE_Q16 - par[a]);
        mul[a][i]  = 34'(p_q[a][i]) * 34'(fac[a][i]) + 34'd32768;
        p_d[a][i]  = act[a] ? mul[a][i][32:16] : p_q[a][i];
        capm[a][i] = 23'(p_q[a][i]) * 23'(BINOM_TAB[nm1[a]][i]);
        w_d[a][i]  = (capm[a][i] > 23'(ONE_Q16)) ? ONE_Q16 : capm[a][i][16:0];
      end
    end
  end

  assign wprod = 34'(w_q[0][cmd_i.acc_k]) * 34'(w_q[1][cmd_i.acc_l]) + 34'd32768;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cur[c]  = rd_vld_q ? $signed(rdata[c*CoordW +: CoordW]) : '0;
      rsum[c] = prod_q[c] + ProdW'(32'sd32768);
      if (cmd_i.pt_write) begin
        new_pt[c] = sat_cw(XW'(dcoord[c]));
      end else begin
        new_pt[c] = sat_cw(XW'(cur[c]) + XW'(dcoord[c]));
      end
    end
  end

  assign ram_we    = cmd_i.pt_write | cmd_i.pt_move;
  assign ram_re    = cmd_i.pt_read | cmd_i.acc_issue;
  assign ram_raddr = cmd_i.acc_issue ? cmd_i.acc_addr : item_q.point_index;

  bsev_ram #(
    .Width (3 * CoordW),
    .Depth (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (item_q.point_index),
    .wdata_i ({new_pt[2], new_pt[1], new_pt[0]}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      iss_q   <= 1'b0;
      mul_q   <= 1'b0;
    end else begin
      iss_q <= cmd_i.acc_issue;
      mul_q <= iss_q;
      if (ram_we) begin
        valid_q[item_q.point_index] <= 1'b1;
      end
    end
  end

  always_comb begin
    res_d        = '0;
    res_d.status = cmd_i.res_status;
    unique case (cmd_i.res_sel)
      RES_POINT: begin
        res_d.pos_x = pos[0];
        res_d.pos_y = pos[1];
        res_d.pos_z = pos[2];
      end
      RES_EVAL: begin
        res_d.pos_x   = pos[0];
        res_d.pos_y   = pos[1];
        res_d.pos_z   = pos[2];
        res_d.param_u = par[0];
        res_d.param_v = par[1];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= item_i;
      for (int a = 0; a < 2; a++) begin
        quo_q[a] <= NUM_W'({sidx[a], 16'h0000}) + NUM_W'(den[a][11:1]);
        rem_q[a] <= '0;
        for (int i = 0; i < MD; i++) begin
          p_q[a][i] <= ONE_Q16;
        end
      end
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= '0;
      end
    end else begin
      if (cmd_i.div_step) begin
        for (int a = 0; a < 2; a++) begin
          quo_q[a] <= quo_d[a];
          rem_q[a] <= rem_d[a];
        end
      end
      if (cmd_i.bern_step) begin
        p_q <= p_d;
      end
      if (mul_q) begin
        for (int c = 0; c < 3; c++) begin
          acc_q[c] <= acc_q[c] + AccW'($signed(rsum[c][ProdW-1:16]));
        end
      end
    end
    if (cmd_i.bern_cap) begin
      w_q <= w_d;
    end
    if (ram_re) begin
      rd_vld_q <= valid_q[ram_raddr];
    end
    if (cmd_i.acc_issue) begin
      wt_q <= wprod[32:16];
    end
    if (iss_q) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= ProdW'($signed({1'b0, wt_q})) * ProdW'(cur[c]);
      end
    end
    if (ram_we) begin
      pt_q <= new_pt;
    end
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (cmd_i.res_sel == RES_POINT) begin
        pos[c] = sat_32(XW'(pt_q[c]));
      end else begin
        pos[c] = sat_32(XW'(sat_cw(XW'(acc_q[c]))));
      end
    end
  end

  assign result_o = res_q;

endmodule

FILE: rtl/bsev_ctrl.sv
// ----------------------------------------------------------------------------
// bsev_ctrl
// Controller: checks each item and sequences the datapath.
// ----------------------------------------------------------------------------
module bsev_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  bsev_pkg::in_item_t item_i,
  input  bsev_pkg::cfg_t     cfg_i,
  output logic               busy_o,
  output logic               done_o,
  output bsev_pkg::cmd_t     cmd_o
);
  import bsev_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_BERN  = 4'd2;
  localparam logic [3:0] S_CAP   = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_DRAIN = 4'd5;
  localparam logic [3:0] S_WRITE = 4'd6;
  localparam logic [3:0] S_READ  = 4'd7;
  localparam logic [3:0] S_MOVE  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [DIM_IW-1:0] k_q, k_d, l_q, l_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [1:0]        sel_q, sel_d;
  logic [1:0]        stat_q, stat_d;
  logic              done_q, done_d;
  logic [7:0]        npts;
  logic              last;

  assign npts = 8'(cfg_i.ppr) * 8'(cfg_i.rop);
  assign last = ({2'b00, addr_q} == 8'(npts - 8'd1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    l_d     = l_q;
    addr_d  = addr_q;
    sel_d   = sel_q;
    stat_d  = stat_q;
    done_d  = 1'b0;
    cmd_o            = '0;
    cmd_o.bern_idx   = cnt_q[DIM_IW-1:0];
    cmd_o.acc_addr   = addr_q;
    cmd_o.acc_k      = k_q;
    cmd_o.acc_l      = l_q;
    cmd_o.res_sel    = sel_q;
    cmd_o.res_status = stat_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_item = 1'b1;
          sel_d   = RES_ZERO;
          stat_d  = ST_OK;
          state_d = S_DONE;
          cnt_d   = '0;
          unique case (item_i.operation)
            OP_WRITE, OP_MOVE: begin
              if ({2'b00, item_i.point_index} >= npts) begin
                stat_d = ST_BAD_INDEX;
              end else begin
                sel_d   = RES_POINT;
                state_d = (item_i.operation == OP_WRITE) ? S_WRITE : S_READ;
              end
            end
            OP_EVAL: begin
              if (cfg_i.ppr < 4'd2 || cfg_i.rop < 4'd2) begin
                stat_d = ST_FEW_PTS;
              end else if ({1'b0, item_i.sample_u_index} > 13'(cfg_i.su - 13'd1) ||
                           {1'b0, item_i.sample_v_index} > 13'(cfg_i.sv - 13'd1)) begin
                stat_d = ST_BAD_INDEX;
              end else begin
                sel_d   = RES_EVAL;
                state_d = S_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == 5'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_BERN;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_BERN: begin
        cmd_o.bern_step = 1'b1;
        if (cnt_q == 5'(MAX_GRID_DIM - 2)) begin
          cnt_d   = '0;
          state_d = S_CAP;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_CAP: begin
        cmd_o.bern_cap = 1'b1;
        addr_d  = '0;
        k_d     = '0;
        l_d     = '0;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_issue = 1'b1;
        addr_d = addr_q + ADDR_W'(1);
        if ({1'b0, k_q} == 4'(cfg_i.ppr - 4'd1)) begin
          k_d = '0;
          l_d = l_q + DIM_IW'(1);
        end else begin
          k_d = k_q + DIM_IW'(1);
        end
        if (last) begin
          cnt_d   = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (cnt_q == 5'd1) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_WRITE: begin
        cmd_o.pt_write = 1'b1;
        state_d = S_DONE;
      end
      S_READ: begin
        cmd_o.pt_read = 1'b1;
        state_d = S_MOVE;
      end
      S_MOVE: begin
        cmd_o.pt_move = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.res_load = 1'b1;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      l_q     <= '0;
      addr_q  <= '0;
      sel_q   <= RES_ZERO;
      stat_q  <= ST_OK;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      l_q     <= l_d;
      addr_q  <= addr_d;
      sel_q   <= sel_d;
      stat_q  <= stat_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

FILE: rtl/bezier_surface_evaluator_unit.sv
// ----------------------------------------------------------------------------
// bezier_surface_evaluator_unit
// Evaluation: the 28-step parameter divider, then the Bernstein lanes, then the
//   accumulation of points_per_row * rows_of_points points at one point per cycle.
// Throughput: one item at a time; start is taken again in the cycle done is high.
// Reset: control points read as zero, grid 2 x 2, samples 2 x 2.
// ----------------------------------------------------------------------------
module bezier_surface_evaluator_unit #(
  parameter int COORD_WIDTH = bsev_pkg::COORD_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bsev_pkg::in_item_t  in_i,
  output logic                done_o,
  output bsev_pkg::out_item_t result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [12:0]         cfg_data_i
);
  import bsev_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;

  function automatic logic [3:0] sat_dim(input logic [3:0] v);
    return (v > 4'(MAX_GRID_DIM)) ? 4'(MAX_GRID_DIM) : v;
  endfunction

  function automatic logic [12:0] sat_smp(input logic [12:0] v);
    if (v < 13'd2) return 13'd2;
    if (v > 13'd4096) return 13'd4096;
    return v;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ppr <= 4'd2;
      cfg_q.rop <= 4'd2;
      cfg_q.su  <= 13'd2;
      cfg_q.sv  <= 13'd2;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PPR: cfg_q.ppr <= sat_dim(cfg_data_i[3:0]);
        CFG_ROP: cfg_q.rop <= sat_dim(cfg_data_i[3:0]);
        CFG_SU:  cfg_q.su  <= sat_smp(cfg_data_i);
        CFG_SV:  cfg_q.sv  <= sat_smp(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  bsev_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .item_i  (in_i),
    .cfg_i   (cfg_q),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  bsev_dp #(
    .CoordW (COORD_WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cmd_i    (cmd),
    .item_i   (in_i),
    .result_o (result_o)
  );

endmodule

FILE: test/tb_bezier_surface_evaluator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bezier_surface_evaluator_unit
// Self-checking bench for the Bezier surface evaluator. A short table of
// directed items, some with hand-typed results, is followed by random point
// writes, moves and evaluations over several grid and sample settings. All
// other results are checked against an in-bench surface predictor.
// ----------------------------------------------------------------------------
module tb_bezier_surface_evaluator_unit;
  import bsev_pkg::*;

  localparam logic [1:0] OP_NONE  = 2'd3;
  localparam longint     Q_ONE    = 65536;
  localparam longint     C32_MAX  = 64'sh7fffffff;
  localparam longint     C32_MIN  = -64'sh80000000;

  typedef longint unsigned wvec_t [MAX_GRID_DIM];

  typedef struct {
    bit        pinned;
    out_item_t val;
  } pinned_t;

  typedef struct {
    in_item_t  item;
    bit        pinned;
    out_item_t val;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        done;
  out_item_t   result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  longint      point_store [STORE_DEPTH][3];
  int unsigned grid_u, grid_v, nsamp_u, nsamp_v;
  out_item_t   surface_q [$];
  pinned_t     pinned_q [$];
  int          errors = 0;
  bit          idle_on = 1'b1;

  bezier_surface_evaluator_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .in_i       (in_item),
    .done_o     (done),
    .result_o   (result),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  function automatic longint sat32(input longint x);
    return (x > C32_MAX) ? C32_MAX : ((x < C32_MIN) ? C32_MIN : x);
  endfunction

  function automatic wvec_t bern_weights(input int unsigned n, input longint unsigned t);
    longint unsigned binom [MAX_GRID_DIM];
    longint unsigned p;
    wvec_t w;
    for (int i = 0; i < MAX_GRID_DIM; i++) begin
      binom[i] = 0;
      w[i] = 0;
    end
    binom[0] = 1;
    for (int i = 0; i < n; i++)
      for (int j = i; j > 0; j--)
        binom[j] += binom[j-1];
    for (int i = 0; i < n; i++) begin
      p = Q_ONE;
      for (int a = 0; a < i; a++) p = (p * t + 32768) >> 16;
      for (int a = 0; a + 1 + i < n; a++) p = (p * (Q_ONE - t) + 32768) >> 16;
      p = p * binom[i];
      w[i] = (p > Q_ONE) ? Q_ONE : p;
    end
    return w;
  endfunction

  function automatic out_item_t surface_predict(input in_item_t it);
    out_item_t r;
    longint d [3];
    longint acc [3];
    longint unsigned du, dv, pu, pv, wt;
    wvec_t wu, wv;
    int idx;
    r = '0;
    d[0] = longint'(it.coord_x);
    d[1] = longint'(it.coord_y);
    d[2] = longint'(it.coord_z);
    idx = int'(it.point_index);
    if (it.operation == OP_WRITE || it.operation == OP_MOVE) begin
      if (idx >= grid_u * grid_v) begin
        r.status = ST_BAD_INDEX;
      end else begin
        for (int c = 0; c < 3; c++)
          point_store[idx][c] = (it.operation == OP_WRITE) ? d[c]
                                : sat32(point_store[idx][c] + d[c]);
        r.pos_x = point_store[idx][0][31:0];
        r.pos_y = point_store[idx][1][31:0];
        r.pos_z = point_store[idx][2][31:0];
      end
    end else if (it.operation == OP_EVAL) begin
      if (grid_u < 2 || grid_v < 2) begin
        r.status = ST_FEW_PTS;
      end else if (it.sample_u_index > nsamp_u - 1 || it.sample_v_index > nsamp_v - 1) begin
        r.status = ST_BAD_INDEX;
      end else begin
        du = nsamp_u - 1;
        dv = nsamp_v - 1;
        pu = (longint'(it.sample_u_index) * Q_ONE + du / 2) / du;
        pv = (longint'(it.sample_v_index) * Q_ONE + dv / 2) / dv;
        wu = bern_weights(grid_u, pu);
        wv = bern_weights(grid_v, pv);
        for (int c = 0; c < 3; c++) acc[c] = 0;
        for (int l = 0; l < grid_v; l++)
          for (int k = 0; k < grid_u; k++) begin
            wt = (wu[k] * wv[l] + 32768) >> 16;
            for (int c = 0; c < 3; c++)
              acc[c] += (longint'(wt) * point_store[l * grid_u + k][c] + 32768) >>> 16;
          end
        r.pos_x = 32'(sat32(acc[0]));
        r.pos_y = 32'(sat32(acc[1]));
        r.pos_z = 32'(sat32(acc[2]));
        r.param_u = pu[16:0];
        r.param_v = pv[16:0];
      end
    end
    return r;
  endfunction

  // transfer monitor: config, accepted items and results
  always @(posedge clk) begin
    out_item_t exp_r;
    pinned_t pin;
    if (rst_n) begin
      if (done) begin
        if (surface_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          exp_r = surface_q.pop_front();
          if (result.pos_x !== exp_r.pos_x) begin
            $error("pos_x exp %h got %h", exp_r.pos_x, result.pos_x); errors++;
          end
          if (result.pos_y !== exp_r.pos_y) begin
            $error("pos_y exp %h got %h", exp_r.pos_y, result.pos_y); errors++;
          end
          if (result.pos_z !== exp_r.pos_z) begin
            $error("pos_z exp %h got %h", exp_r.pos_z, result.pos_z); errors++;
          end
          if (result.param_u !== exp_r.param_u) begin
            $error("param_u exp %0d got %0d", exp_r.param_u, result.param_u); errors++;
          end
          if (result.param_v !== exp_r.param_v) begin
            $error("param_v exp %0d got %0d", exp_r.param_v, result.param_v); errors++;
          end
          if (result.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, result.status); errors++;
          end
        end
      end
      if (start && !busy) begin
        exp_r = surface_predict(in_item);
        if (pinned_q.size() != 0) begin
          pin = pinned_q.pop_front();
          if (pin.pinned) exp_r = pin.val;
        end
        surface_q.insert(surface_q.size(), exp_r);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PPR: grid_u = (cfg_data[3:0] > MAX_GRID_DIM) ? MAX_GRID_DIM : cfg_data[3:0];
          CFG_ROP: grid_v = (cfg_data[3:0] > MAX_GRID_DIM) ? MAX_GRID_DIM : cfg_data[3:0];
          CFG_SU:  nsamp_u = (cfg_data < 2) ? 2 : ((cfg_data > 4096) ? 4096 : cfg_data);
          CFG_SV:  nsamp_v = (cfg_data < 2) ? 2 : ((cfg_data > 4096) ? 4096 : cfg_data);
          default: ;
        endcase
      end
    end
  end

  task automatic send_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] index, input logic [12:0] data);
    if (idle_on && $urandom_range(0, 99) < 25) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (surface_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 2 * Q_ONE) - Q_ONE);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int r;
    it.coord_x = rand_coord();
    it.coord_y = rand_coord();
    it.coord_z = rand_coord();
    r = $urandom_range(0, 99);
    it.operation = (r < 30) ? OP_WRITE : (r < 50) ? OP_MOVE : (r < 97) ? OP_EVAL : OP_NONE;
    if ($urandom_range(0, 9) == 0 || grid_u * grid_v == 0)
      it.point_index = 6'($urandom);
    else
      it.point_index = 6'($urandom_range(0, grid_u * grid_v - 1));
    if ($urandom_range(0, 9) == 0) begin
      it.sample_u_index = 12'($urandom);
      it.sample_v_index = 12'($urandom);
    end else begin
      it.sample_u_index = 12'($urandom_range(0, nsamp_u - 1));
      it.sample_v_index = 12'($urandom_range(0, nsamp_v - 1));
    end
    return it;
  endfunction

  function automatic in_item_t mk(input logic [1:0] op, input logic [5:0] idx,
                                  input logic [31:0] x, input logic [31:0] y,
                                  input logic [31:0] z, input logic [11:0] i,
                                  input logic [11:0] j);
    in_item_t it;
    it = '{op, idx, x, y, z, i, j};
    return it;
  endfunction

  function automatic out_item_t res(input logic [31:0] x, input logic [31:0] y,
                                    input logic [31:0] z, input logic [16:0] u,
                                    input logic [16:0] v, input logic [1:0] st);
    out_item_t r;
    r = '{x, y, z, u, v, st};
    return r;
  endfunction

  row_t directed [$];
  int   phase_cfg [$][4];

  initial begin
    pinned_t pin;
    for (int i = 0; i < STORE_DEPTH; i++)
      for (int c = 0; c < 3; c++) point_store[i][c] = 0;
    grid_u = 2; grid_v = 2; nsamp_u = 2; nsamp_v = 2;

    directed = '{
      '{mk(OP_EVAL, 0, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0, 0, ST_OK)},
      '{mk(OP_EVAL, 0, 0, 0, 0, 1, 1), 1, res(0, 0, 0, ONE_Q16, ONE_Q16, ST_OK)},
      '{mk(OP_WRITE, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0), 1,
        res(32'h7fffffff, 32'h80000000, 0, 0, 0, ST_OK)},
      '{mk(OP_WRITE, 3, 32'hffffffff, 1, 12345, 12'hfff, 12'hfff), 1,
        res(32'hffffffff, 1, 12345, 0, 0, ST_OK)},
      '{mk(OP_MOVE, 0, 1, 32'hffffffff, 0, 0, 0), 1,
        res(32'h7fffffff, 32'h80000000, 0, 0, 0, ST_OK)},
      '{mk(OP_WRITE, 4, 5, 5, 5, 0, 0), 1, res(0, 0, 0, 0, 0, ST_BAD_INDEX)},
      '{mk(OP_MOVE, 63, 5, 5, 5, 0, 0), 1, res(0, 0, 0, 0, 0, ST_BAD_INDEX)},
      '{mk(OP_EVAL, 0, 0, 0, 0, 2, 0), 1, res(0, 0, 0, 0, 0, ST_BAD_INDEX)},
      '{mk(OP_EVAL, 0, 0, 0, 0, 0, 12'hfff), 1, res(0, 0, 0, 0, 0, ST_BAD_INDEX)},
      '{mk(OP_NONE, 63, 32'hffffffff, 32'hffffffff, 32'hffffffff, 12'hfff, 12'hfff), 1,
        res(0, 0, 0, 0, 0, ST_OK)},
      '{mk(OP_EVAL, 0, 0, 0, 0, 0, 0), 1,
        res(32'h7fffffff, 32'h80000000, 0, 0, 0, ST_OK)},
      '{mk(OP_EVAL, 0, 0, 0, 0, 1, 1), 1,
        res(32'hffffffff, 1, 12345, ONE_Q16, ONE_Q16, ST_OK)},
      '{mk(OP_WRITE, 1, 32'h00010000, 32'h7fffffff, 32'h80000000, 0, 0), 0, '0},
      '{mk(OP_WRITE, 2, 32'h80000000, 32'h00020000, 32'h7fffffff, 0, 0), 0, '0},
      '{mk(OP_EVAL, 0, 0, 0, 0, 1, 0), 0, '0},
      '{mk(OP_MOVE, 3, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0), 0, '0}
    };
    phase_cfg = '{'{8, 8, 4096, 4096}, '{15, 15, 8191, 8191}, '{1, 2, 0, 2},
                  '{3, 5, 7, 3}, '{2, 8, 2, 4096}, '{0, 0, 5, 5}, '{8, 2, 1, 9},
                  '{4, 4, 3, 3}, '{2, 2, 4096, 2}, '{7, 6, 33, 17}};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[n]) begin
      pin.pinned = directed[n].pinned;
      pin.val = directed[n].val;
      pinned_q.insert(pinned_q.size(), pin);
      send_item(directed[n].item);
    end

    foreach (phase_cfg[p]) begin
      drain();
      idle_on = (p != 4);
      write_cfg(CFG_PPR, 13'(phase_cfg[p][0]));
      write_cfg(CFG_ROP, 13'(phase_cfg[p][1]));
      write_cfg(CFG_SU, 13'(phase_cfg[p][2]));
      write_cfg(CFG_SV, 13'(phase_cfg[p][3]));
      cfg_valid <= 1'b0;
      @(posedge clk);
      repeat (120) send_item(rand_item());
    end

    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
